FILE: sv/modbus_frame_payload_parser_defines.svh
// Assertion macros used by the Modbus frame parser RTL.
`ifndef MODBUS_FRAME_PAYLOAD_PARSER_DEFINES_SVH
`define MODBUS_FRAME_PAYLOAD_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MBFP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MBFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/mbfp_pkg.sv
// Package: constants, types and helpers of the Modbus frame parser.
`default_nettype none
package mbfp_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int MIN_FRAME_BYTES = 8;
   localparam int COILS_PER_BYTE  = 8;
   localparam int WIDE_REG_BYTES  = 4;

   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
   localparam logic [7:0] FC_WRITE_REG      = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_SHORT       = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ST_TRUNCATED   = 2'd3;

   localparam logic [1:0] CSR_ROLE      = 2'd0;
   localparam logic [1:0] CSR_START     = 2'd1;
   localparam logic [1:0] CSR_REG_BYTES = 2'd2;

   typedef struct packed {
      logic        role_is_slave;
      logic [15:0] response_start_address;
      logic [2:0]  response_register_bytes;
   } mbfp_cfg_type;

   // Results caused by one accepted byte: up to eight items, then maybe a summary.
   typedef struct packed {
      logic        valid;
      logic [3:0]  count;
      logic        is_coil;
      logic [15:0] addr;
      logic [31:0] value;
      logic [7:0]  coil_bits;
      logic        summary;
      logic [1:0]  status;
      logic [7:0]  dev;
      logic [7:0]  func;
      logic [7:0]  bcount;
   } mbfp_batch_type;

   function automatic logic fc_single(input logic [7:0] f);
      return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG);
   endfunction

   function automatic logic fc_supported(input logic [7:0] f, input logic slave);
      logic ok;
      if (fc_single(f)) begin
         ok = 1'b1;
      end else if (slave) begin
         ok = (f == FC_READ_COILS) || (f == FC_READ_HOLDING);
      end else begin
         ok = (f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
      end
      return ok;
   endfunction

endpackage
`default_nettype wire

FILE: sv/mbfp_req_if.sv
// Request channel: one frame byte per item.
`default_nettype none
interface mbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       first_of_frame;
   logic       end_of_frame;

   modport source (output valid, frame_byte, first_of_frame, end_of_frame, input ready);
   modport sink   (input valid, frame_byte, first_of_frame, end_of_frame, output ready);
endinterface
`default_nettype wire

FILE: sv/mbfp_rsp_if.sv
// Response channel: one decoded item or frame summary per item.
`default_nettype none
interface mbfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  device_address;
   logic [7:0]  function_code;
   logic        item_valid;
   logic        item_is_coil;
   logic [15:0] item_address;
   logic [31:0] item_value;
   logic [7:0]  byte_count_field;
   logic [1:0]  frame_status;
   logic        last;

   modport source (output valid, device_address, function_code, item_valid, item_is_coil,
                   item_address, item_value, byte_count_field, frame_status, last,
                   input ready);
   modport sink   (input valid, device_address, function_code, item_valid, item_is_coil,
                   item_address, item_value, byte_count_field, frame_status, last,
                   output ready);
endinterface
`default_nettype wire

FILE: sv/mbfp_frame.sv
// Frame state tracker: header capture, two-byte holdback and body decode per byte.
`default_nettype none
module mbfp_frame
   import mbfp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step_en,
   input  wire logic [7:0]     frame_byte,
   input  wire logic           first_of_frame,
   input  wire logic           end_of_frame,
   input  wire mbfp_cfg_type   cfg,
   output mbfp_batch_type      batch
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       held0_ff, held0_in, held1_ff, held1_in;
   logic [7:0]       addr_ff, addr_in, func_ff, func_in;
   logic [15:0]      start_ff, start_in, qty_ff, qty_in;
   logic [7:0]       bcount_ff, bcount_in;
   logic [31:0]      va_ff, va_in;
   logic [1:0]       rbi_ff, rbi_in;
   logic [15:0]      emitted_ff, emitted_in;
   logic             wide_ff, wide_in;

   logic [3:0]  n_items;
   logic        is_coil;
   logic [31:0] item_value;
   logic [7:0]  coil_bits;
   logic        summary;
   logic [1:0]  status;
   logic [15:0] remaining;
   logic [2:0]  reg_count;
   logic [2:0]  reg_need;
   logic [31:0] va_shift;
   logic [18:0] qty_x4, qty_x5, byte_ext;
   logic [7:0]  body;
   logic [15:0] expected;

   always_comb begin
      pos_in     = pos_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      addr_in    = addr_ff;
      func_in    = func_ff;
      start_in   = start_ff;
      qty_in     = qty_ff;
      bcount_in  = bcount_ff;
      va_in      = va_ff;
      rbi_in     = rbi_ff;
      wide_in    = wide_ff;
      n_items    = 4'd0;
      is_coil    = 1'b0;
      item_value = 32'd0;
      coil_bits  = 8'd0;
      summary    = 1'b0;
      body       = held0_ff;
      remaining  = qty_ff - emitted_ff;
      reg_count  = {1'b0, rbi_ff} + 3'd1;
      reg_need   = wide_ff ? 3'(WIDE_REG_BYTES) : 3'd2;
      va_shift   = {va_ff[23:0], held0_ff};
      qty_x4     = {1'b0, qty_ff, 2'b00};
      qty_x5     = qty_x4 + {3'b000, qty_ff};
      byte_ext   = {11'd0, held0_ff};

      if (first_of_frame) begin
         held0_in  = 8'd0;
         held1_in  = 8'd0;
         func_in   = 8'd0;
         start_in  = 16'd0;
         qty_in    = 16'd0;
         bcount_in = 8'd0;
         va_in     = 32'd0;
         rbi_in    = 2'd0;
         wide_in   = 1'b0;
         addr_in   = frame_byte;
         pos_in    = POS_W'(1);
         summary   = end_of_frame;
      end else if (pos_ff != '0) begin
         if (pos_ff < POS_W'(MAX_FRAME_BYTES)) begin
            if (pos_ff == POS_W'(1)) begin
               func_in = frame_byte;
            end else if (pos_ff >= POS_W'(4)) begin
               if (fc_supported(func_ff, cfg.role_is_slave)) begin
                  if (fc_single(func_ff)) begin
                     if (pos_ff == POS_W'(4)) begin
                        start_in = {body, 8'd0};
                     end else if (pos_ff == POS_W'(5)) begin
                        start_in = start_ff | {8'd0, body};
                     end else if (pos_ff == POS_W'(6)) begin
                        va_in = {24'd0, body};
                     end else if (pos_ff == POS_W'(7) && emitted_ff == 16'd0) begin
                        n_items    = 4'd1;
                        item_value = {16'd0, va_ff[7:0], body};
                     end
                  end else if (!cfg.role_is_slave) begin
                     if (pos_ff == POS_W'(4)) begin
                        start_in = {body, 8'd0};
                     end else if (pos_ff == POS_W'(5)) begin
                        start_in = start_ff | {8'd0, body};
                     end else if (pos_ff == POS_W'(6)) begin
                        qty_in = {body, 8'd0};
                     end else if (pos_ff == POS_W'(7)) begin
                        qty_in = qty_ff | {8'd0, body};
                     end else if (pos_ff == POS_W'(8)) begin
                        bcount_in = body;
                        // byte_count / quantity == 4  <=>  4q <= bc < 5q
                        wide_in = (qty_ff != 16'd0) && (qty_x4 <= byte_ext) &&
                                  (byte_ext < qty_x5);
                     end else if (func_ff == FC_WRITE_COILS) begin
                        is_coil = 1'b1;
                     end else begin
                        if (reg_count >= reg_need) begin
                           if (emitted_ff < qty_ff) begin
                              n_items    = 4'd1;
                              item_value = wide_ff ? va_shift : {16'd0, va_shift[15:0]};
                           end
                           va_in  = 32'd0;
                           rbi_in = 2'd0;
                        end else begin
                           va_in  = va_shift;
                           rbi_in = reg_count[1:0];
                        end
                     end
                  end else begin
                     if (pos_ff == POS_W'(4)) begin
                        bcount_in = body;
                        start_in  = cfg.response_start_address;
                        if (func_ff == FC_READ_COILS) begin
                           qty_in = {5'd0, body, 3'd0};
                        end else begin
                           wide_in = (cfg.response_register_bytes == 3'(WIDE_REG_BYTES));
                           qty_in  = wide_in ? {10'd0, body[7:2]} : {9'd0, body[7:1]};
                        end
                     end else if (func_ff == FC_READ_COILS) begin
                        is_coil = 1'b1;
                     end else begin
                        if (reg_count >= reg_need) begin
                           if (emitted_ff < qty_ff) begin
                              n_items    = 4'd1;
                              item_value = wide_ff ? va_shift : {16'd0, va_shift[15:0]};
                           end
                           va_in  = 32'd0;
                           rbi_in = 2'd0;
                        end else begin
                           va_in  = va_shift;
                           rbi_in = reg_count[1:0];
                        end
                     end
                  end
                  if (is_coil && emitted_ff < qty_ff) begin
                     coil_bits = body;
                     n_items   = (remaining > 16'(COILS_PER_BYTE)) ?
                                 4'(COILS_PER_BYTE) : remaining[3:0];
                  end
               end
               held0_in = held1_ff;
               held1_in = frame_byte;
            end else if (pos_ff == POS_W'(2)) begin
               held0_in = frame_byte;
            end else begin
               held1_in = frame_byte;
            end
            pos_in = pos_ff + POS_W'(1);
         end
         summary = end_of_frame;
      end

      emitted_in = emitted_ff + {12'd0, n_items};
      if (first_of_frame) begin
         emitted_in = 16'd0;
      end

      expected = fc_single(func_in) ? 16'd1 : qty_in;
      priority if (pos_in < POS_W'(MIN_FRAME_BYTES)) begin
         status = ST_SHORT;
      end else if (!fc_supported(func_in, cfg.role_is_slave)) begin
         status = ST_UNSUPPORTED;
      end else if (emitted_in < expected) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_OK;
      end
      if (summary) begin
         pos_in = '0;
      end
   end

   assign batch.valid     = (n_items != 4'd0) || summary;
   assign batch.count     = n_items;
   assign batch.is_coil   = is_coil;
   assign batch.addr      = start_ff + emitted_ff;
   assign batch.value     = item_value;
   assign batch.coil_bits = coil_bits;
   assign batch.summary   = summary;
   assign batch.status    = status;
   assign batch.dev       = addr_in;
   assign batch.func      = func_in;
   assign batch.bcount    = bcount_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         held0_ff   <= 8'd0;
         held1_ff   <= 8'd0;
         addr_ff    <= 8'd0;
         func_ff    <= 8'd0;
         start_ff   <= 16'd0;
         qty_ff     <= 16'd0;
         bcount_ff  <= 8'd0;
         va_ff      <= 32'd0;
         rbi_ff     <= 2'd0;
         emitted_ff <= 16'd0;
         wide_ff    <= 1'b0;
      end else if (step_en) begin
         pos_ff     <= pos_in;
         held0_ff   <= held0_in;
         held1_ff   <= held1_in;
         addr_ff    <= addr_in;
         func_ff    <= func_in;
         start_ff   <= start_in;
         qty_ff     <= qty_in;
         bcount_ff  <= bcount_in;
         va_ff      <= va_in;
         rbi_ff     <= rbi_in;
         emitted_ff <= emitted_in;
         wide_ff    <= wide_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/modbus_frame_payload_parser.sv
// Top level of the Modbus RTU frame payload parser.
//
// req_chan takes one frame byte per item with first_of_frame on the address
// byte and end_of_frame on the last CRC byte. rsp_chan gives address/value
// items (coil bits, 16- or 32-bit registers) and one summary item with last
// set at the end of every frame. Bytes outside a frame are dropped silently.
// The csr_ port writes role, slave start address and slave register width;
// write it only while no frame results are pending.
// Results of an accepted byte pass through a result queue register, then the output register.
// Throughput: one byte per cycle while each byte yields at most one item and rsp_chan is not stalled.
// A byte that yields n items (n up to 8 coil bits, plus the summary) holds
// req_chan.ready low while the result queue register drains into the output
// register one item per cycle.
// A stalled rsp_chan holds its item; the queue register keeps accepting
// until it also fills, then req_chan.ready drops.
// Reset (synchronous) closes any open frame and empties both registers;
// the slave register width resets to 4 bytes.
`default_nettype none
`include "modbus_frame_payload_parser_defines.svh"
module modbus_frame_payload_parser
   import mbfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   mbfp_req_if.sink         req_chan,
   mbfp_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   mbfp_cfg_type   cfg_ff;
   mbfp_batch_type step_batch;
   mbfp_batch_type batch_ff, batch_in;
   logic           batch_valid_ff, batch_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_dev_ff, rsp_func_ff, rsp_bcount_ff;
   logic           rsp_item_ff, rsp_coil_ff, rsp_last_ff;
   logic [15:0]    rsp_addr_ff;
   logic [31:0]    rsp_value_ff;
   logic [1:0]     rsp_status_ff;

   logic out_free, batch_move, batch_item, batch_done_now, req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.role_is_slave           <= 1'b0;
         cfg_ff.response_start_address  <= 16'd0;
         cfg_ff.response_register_bytes <= 3'(WIDE_REG_BYTES);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ROLE) begin
            cfg_ff.role_is_slave <= csr_write_data[0];
         end else if (csr_index == CSR_START) begin
            cfg_ff.response_start_address <= csr_write_data;
         end else if (csr_index == CSR_REG_BYTES) begin
            cfg_ff.response_register_bytes <= csr_write_data[2:0];
         end
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign batch_move     = batch_valid_ff && out_free;
   assign batch_item     = (batch_ff.count != 4'd0);
   assign batch_done_now = batch_move &&
                           (!batch_item || (batch_ff.count == 4'd1 && !batch_ff.summary));
   assign req_chan.ready = !batch_valid_ff || batch_done_now;
   assign req_fire       = req_chan.valid && req_chan.ready;

   mbfp_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .step_en        (req_fire),
      .frame_byte     (req_chan.frame_byte),
      .first_of_frame (req_chan.first_of_frame),
      .end_of_frame   (req_chan.end_of_frame),
      .cfg            (cfg_ff),
      .batch          (step_batch)
   );

   always_comb begin
      batch_in       = batch_ff;
      batch_valid_in = batch_valid_ff;
      if (req_fire) begin
         batch_in       = step_batch;
         batch_valid_in = step_batch.valid;
      end else if (batch_move) begin
         batch_valid_in = !batch_done_now;
         if (batch_item) begin
            batch_in.count     = batch_ff.count - 4'd1;
            batch_in.addr      = batch_ff.addr + 16'd1;
            batch_in.coil_bits = {1'b0, batch_ff.coil_bits[7:1]};
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (batch_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         batch_valid_ff <= batch_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
      if (batch_move) begin
         rsp_dev_ff    <= batch_ff.dev;
         rsp_func_ff   <= batch_ff.func;
         rsp_bcount_ff <= batch_ff.bcount;
         rsp_item_ff   <= batch_item;
         rsp_coil_ff   <= batch_item && batch_ff.is_coil;
         rsp_addr_ff   <= batch_item ? batch_ff.addr : 16'd0;
         rsp_value_ff  <= !batch_item ? 32'd0 :
                          batch_ff.is_coil ? {31'd0, batch_ff.coil_bits[0]} : batch_ff.value;
         rsp_status_ff <= batch_item ? ST_OK : batch_ff.status;
         rsp_last_ff   <= !batch_item;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.device_address   = rsp_dev_ff;
   assign rsp_chan.function_code    = rsp_func_ff;
   assign rsp_chan.item_valid       = rsp_item_ff;
   assign rsp_chan.item_is_coil     = rsp_coil_ff;
   assign rsp_chan.item_address     = rsp_addr_ff;
   assign rsp_chan.item_value       = rsp_value_ff;
   assign rsp_chan.byte_count_field = rsp_bcount_ff;
   assign rsp_chan.frame_status     = rsp_status_ff;
   assign rsp_chan.last             = rsp_last_ff;

   `MBFP_ASSERT_IMPL(a_batch_count_max, batch_valid_ff,
                     batch_ff.count <= 4'(COILS_PER_BYTE),
                     "queued item count above one byte of coils")
   `MBFP_ASSERT_IMPL(a_reg_single, batch_valid_ff && !batch_ff.is_coil,
                     batch_ff.count <= 4'd1,
                     "register byte queued more than one item")
   `MBFP_ASSERT_IMPL(a_item_fields, rsp_valid_ff && rsp_item_ff,
                     rsp_status_ff == ST_OK && !rsp_last_ff,
                     "item result carries summary fields")
   `MBFP_ASSERT_NEXT(a_summary_drains, batch_move && !batch_item && !req_fire,
                     !batch_valid_ff,
                     "queue not empty after its summary left")

endmodule
`default_nettype wire

FILE: dv/modbus_frame_payload_parser_tb.sv
// Testbench for the Modbus RTU frame payload parser: directed and random frames.
`timescale 1ns / 1ps
module modbus_frame_payload_parser_tb
   import mbfp_pkg::*;
;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 16;

   typedef logic [7:0] octet_queue_type[$];

   typedef struct {
      logic [7:0]  dev;
      logic [7:0]  func;
      logic        item_valid;
      logic        is_coil;
      logic [15:0] addr;
      logic [31:0] value;
      logic [7:0]  bcount;
      logic [1:0]  status;
      logic        last;
   } parser_output_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [15:0] csr_write_data;

   mbfp_req_if req_chan ();
   mbfp_rsp_if rsp_chan ();

   modbus_frame_payload_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   parser_output_type parser_outputs_due[$];
   int fail_count = 0;
   int cycle_count = 0;
   int bytes_taken = 0;
   bit steady_flow = 1'b0;

   // configuration copy
   logic        cfg_slave;
   logic [15:0] cfg_start;
   logic [2:0]  cfg_reg_bytes;

   // frame state copy
   int          fr_pos;
   logic [7:0]  fr_held [2];
   logic [7:0]  fr_dev;
   logic [7:0]  fr_func;
   logic [15:0] fr_start;
   logic [15:0] fr_qty;
   logic [7:0]  fr_bcount;
   logic [31:0] fr_acc;
   logic [1:0]  fr_reg_idx;
   logic [15:0] fr_count;
   logic        fr_wide;

   function automatic void clear_frame();
      fr_held[0] = 8'd0;
      fr_held[1] = 8'd0;
      fr_func = 8'd0;
      fr_start = 16'd0;
      fr_qty = 16'd0;
      fr_bcount = 8'd0;
      fr_acc = 32'd0;
      fr_reg_idx = 2'd0;
      fr_count = 16'd0;
      fr_wide = 1'b0;
   endfunction

   function automatic logic func_allowed();
      if (fr_func == FC_WRITE_COIL || fr_func == FC_WRITE_REG) return 1'b1;
      if (cfg_slave) return fr_func == FC_READ_COILS || fr_func == FC_READ_HOLDING;
      return fr_func == FC_WRITE_COILS || fr_func == FC_WRITE_REGS;
   endfunction

   function automatic void push_item(input logic coil, input logic [31:0] value);
      parser_output_type r;
      r.dev = fr_dev;
      r.func = fr_func;
      r.item_valid = 1'b1;
      r.is_coil = coil;
      r.addr = fr_start + fr_count;
      r.value = value;
      r.bcount = fr_bcount;
      r.status = ST_OK;
      r.last = 1'b0;
      parser_outputs_due.push_back(r);
      fr_count = fr_count + 16'd1;
   endfunction

   function automatic void push_summary();
      parser_output_type r;
      int unsigned due;
      due = (fr_func == FC_WRITE_COIL || fr_func == FC_WRITE_REG) ? 1 : int'(fr_qty);
      r.dev = fr_dev;
      r.func = fr_func;
      r.item_valid = 1'b0;
      r.is_coil = 1'b0;
      r.addr = 16'd0;
      r.value = 32'd0;
      r.bcount = fr_bcount;
      r.last = 1'b1;
      if (fr_pos < MIN_FRAME_BYTES) r.status = ST_SHORT;
      else if (!func_allowed()) r.status = ST_UNSUPPORTED;
      else if (int'(fr_count) < due) r.status = ST_TRUNCATED;
      else r.status = ST_OK;
      parser_outputs_due.push_back(r);
      fr_pos = 0;
   endfunction

   function automatic void coil_byte(input logic [7:0] v);
      for (int j = 0; j < COILS_PER_BYTE && fr_count < fr_qty; j++)
         push_item(1'b1, {31'd0, v[j]});
   endfunction

   function automatic void register_byte(input logic [7:0] v);
      int need;
      int cnt;
      need = fr_wide ? WIDE_REG_BYTES : 2;
      cnt = int'(fr_reg_idx) + 1;
      fr_acc = {fr_acc[23:0], v};
      if (cnt >= need) begin
         if (fr_count < fr_qty) push_item(1'b0, fr_wide ? fr_acc : {16'd0, fr_acc[15:0]});
         fr_acc = 32'd0;
         fr_reg_idx = 2'd0;
      end else begin
         fr_reg_idx = 2'(cnt);
      end
   endfunction

   function automatic void body_byte(input int b, input logic [7:0] v);
      if (fr_func == FC_WRITE_COIL || fr_func == FC_WRITE_REG) begin
         if (b == 0) fr_start = {v, 8'd0};
         else if (b == 1) fr_start[7:0] = v;
         else if (b == 2) fr_acc = {24'd0, v};
         else if (b == 3 && fr_count == 16'd0) push_item(1'b0, {16'd0, fr_acc[7:0], v});
      end else if (!cfg_slave) begin
         if (b == 0) fr_start = {v, 8'd0};
         else if (b == 1) fr_start[7:0] = v;
         else if (b == 2) fr_qty = {v, 8'd0};
         else if (b == 3) fr_qty[7:0] = v;
         else if (b == 4) begin
            fr_bcount = v;
            fr_wide = (fr_qty != 16'd0) && ((16'(v) / fr_qty) == 16'd4);
         end else if (fr_func == FC_WRITE_COILS) coil_byte(v);
         else register_byte(v);
      end else begin
         if (b == 0) begin
            fr_bcount = v;
            fr_start = cfg_start;
            if (fr_func == FC_READ_COILS) begin
               fr_qty = {5'd0, v, 3'd0};
            end else begin
               fr_wide = (cfg_reg_bytes == 3'd4);
               fr_qty = 16'(v) / (fr_wide ? 16'd4 : 16'd2);
            end
         end else if (fr_func == FC_READ_COILS) coil_byte(v);
         else register_byte(v);
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] v, input logic sof, input logic eof);
      if (sof) begin
         bytes_taken++;
         clear_frame();
         fr_dev = v;
         fr_pos = 1;
         if (eof) push_summary();
         return;
      end
      if (fr_pos == 0) return;
      bytes_taken++;
      if (fr_pos < MAX_FRAME_BYTES) begin
         if (fr_pos == 1) begin
            fr_func = v;
         end else if (fr_pos >= 4) begin
            if (func_allowed()) body_byte(fr_pos - 4, fr_held[0]);
            fr_held[0] = fr_held[1];
            fr_held[1] = v;
         end else begin
            fr_held[(fr_pos - 2) & 1] = v;
         end
         fr_pos++;
      end
      if (eof) push_summary();
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      parser_output_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (parser_outputs_due.size() == 0) begin
            $display("%0t: unexpected item expected none actual dev %h func %h last %b",
                     $time, rsp_chan.device_address, rsp_chan.function_code, rsp_chan.last);
            fail_count++;
         end else begin
            want = parser_outputs_due.pop_front();
            check_field("device_address", 32'(want.dev), 32'(rsp_chan.device_address));
            check_field("function_code", 32'(want.func), 32'(rsp_chan.function_code));
            check_field("item_valid", 32'(want.item_valid), 32'(rsp_chan.item_valid));
            check_field("item_is_coil", 32'(want.is_coil), 32'(rsp_chan.item_is_coil));
            check_field("item_address", 32'(want.addr), 32'(rsp_chan.item_address));
            check_field("item_value", want.value, rsp_chan.item_value);
            check_field("byte_count_field", 32'(want.bcount), 32'(rsp_chan.byte_count_field));
            check_field("frame_status", 32'(want.status), 32'(rsp_chan.frame_status));
            check_field("last", 32'(want.last), 32'(rsp_chan.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("modbus_frame_payload_parser test failed");
         $finish;
      end
   end

   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!steady_flow && $urandom_range(0, 7) == 0) begin
            stall = idle_len();
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic sof, input logic eof);
      int unsigned gap;
      gap = 0;
      if (!steady_flow && $urandom_range(0, 2) == 0) gap = idle_len();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_byte <= value;
      req_chan.first_of_frame <= sof;
      req_chan.end_of_frame <= eof;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      parse_byte(value, sof, eof);
   endtask

   // appends two random trailer bytes
   task automatic send_frame(input octet_queue_type body);
      octet_queue_type bytes;
      bytes = body;
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      foreach (bytes[i]) send_byte(bytes[i], i == 0, i == bytes.size() - 1);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (parser_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic slave, input logic [15:0] start,
                            input logic [2:0] reg_bytes);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_ROLE;
      csr_write_data <= {15'd0, slave};
      @(posedge clock);
      csr_index <= CSR_START;
      csr_write_data <= start;
      @(posedge clock);
      csr_index <= CSR_REG_BYTES;
      csr_write_data <= {13'd0, reg_bytes};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_slave = slave;
      cfg_start = start;
      cfg_reg_bytes = reg_bytes;
   endtask

   task automatic test_master_functions();
      settle();
      configure(1'b0, 16'h0000, 3'd4);
      send_frame('{8'h11, FC_WRITE_COILS, 8'h00, 8'h13, 8'h00, 8'h0A, 8'h02, 8'hCD, 8'h01});
      send_frame('{8'hFF, FC_WRITE_REGS, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h04,
                   8'h00, 8'h00, 8'hFF, 8'hFF});
      // wide registers, extra data ignored
      send_frame('{8'h00, FC_WRITE_REGS, 8'h01, 8'h00, 8'h00, 8'h01, 8'h04,
                   8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC});
      send_frame('{8'h33, FC_WRITE_REGS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 8'h02});
      send_frame('{8'h01, FC_WRITE_COIL, 8'h00, 8'hAC, 8'hFF, 8'h00});
      send_frame('{8'h7F, FC_WRITE_REG, 8'h80, 8'h01, 8'h55, 8'hAA});
   endtask

   task automatic test_frame_status();
      settle();
      configure(1'b0, 16'hFFFF, 3'd2);
      send_frame('{8'h09, 8'h2B, 8'h00});
      send_frame('{8'h0A, 8'h2B, 8'h00, 8'h01, 8'h02, 8'h03});
      send_frame('{8'h22, FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'hF0});
      send_byte(8'h44, 1'b1, 1'b1);
   endtask

   task automatic test_framing();
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      // unfinished frame dropped by the next start
      send_byte(8'h21, 1'b1, 1'b0);
      send_byte(FC_WRITE_REG, 1'b0, 1'b0);
      send_byte(8'h12, 1'b0, 1'b0);
      send_frame('{8'h21, FC_WRITE_REG, 8'h00, 8'h01, 8'hBE, 8'hEF});
   endtask

   task automatic test_role_switch();
      settle();
      configure(1'b0, 16'h0040, 3'd4);
      send_byte(8'h31, 1'b1, 1'b0);
      send_byte(FC_WRITE_COILS, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      settle();
      configure(1'b1, 16'h0040, 3'd4);
      send_byte(8'h08, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b0);
      send_byte(8'hC3, 1'b0, 1'b1);
   endtask

   task automatic test_slave_functions();
      settle();
      configure(1'b1, 16'hFFFE, 3'd2);
      send_frame('{8'h05, FC_READ_COILS, 8'h02, 8'h5A, 8'h81});
      send_frame('{8'h06, FC_READ_HOLDING, 8'h04, 8'h12, 8'h34, 8'hAB, 8'hCD});
      send_frame('{8'h10, FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01});
      send_frame('{8'h07, FC_WRITE_REG, 8'h00, 8'h02, 8'h00, 8'h07});
      // coil items released before a short end
      send_frame('{8'h08, FC_READ_COILS, 8'h01, 8'hA5});
      settle();
      configure(1'b1, 16'h0000, 3'd4);
      send_frame('{8'h06, FC_READ_HOLDING, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h01, 8'h23, 8'h45, 8'h67});
      settle();
      configure(1'b1, 16'h1234, 3'd3);
      send_frame('{8'h06, FC_READ_HOLDING, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55});
   endtask

   task automatic random_frame();
      octet_queue_type q;
      logic [7:0] fc;
      logic [15:0] start;
      int unsigned qty, bc, n, keep, width;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
         return;
      end
      case ($urandom_range(0, 3))
         0: fc = cfg_slave ? FC_READ_COILS : FC_WRITE_COILS;
         1: fc = cfg_slave ? FC_READ_HOLDING : FC_WRITE_REGS;
         2: fc = FC_WRITE_COIL;
         default: fc = FC_WRITE_REG;
      endcase
      start = 16'($urandom);
      if ($urandom_range(0, 3) == 0) start[15:4] = '1;
      q.push_back(8'($urandom));
      q.push_back(fc);
      case (fc)
         FC_WRITE_COILS: begin
            qty = $urandom_range(1, 20);
            bc = (qty + 7) / 8;
            q.push_back(start[15:8]);
            q.push_back(start[7:0]);
            q.push_back(8'(qty >> 8));
            q.push_back(8'(qty));
            q.push_back(8'(bc));
         end
         FC_WRITE_REGS: begin
            qty = $urandom_range(1, 4);
            width = $urandom_range(0, 1) != 0 ? 4 : 2;
            bc = qty * width;
            q.push_back(start[15:8]);
            q.push_back(start[7:0]);
            q.push_back(8'(qty >> 8));
            q.push_back(8'(qty));
            q.push_back(8'(bc));
         end
         FC_READ_COILS: begin
            bc = $urandom_range(1, 3);
            q.push_back(8'(bc));
         end
         FC_READ_HOLDING: begin
            bc = $urandom_range(1, 3) * (cfg_reg_bytes == 3'd4 ? 4 : 2);
            if ($urandom_range(0, 4) == 0) bc++;
            q.push_back(8'(bc));
         end
         default: bc = 4;
      endcase
      for (int i = 0; i < bc; i++) q.push_back(8'($urandom));
      case ($urandom_range(0, 7))
         0: begin
            keep = $urandom_range(1, q.size() - 1);
            while (q.size() > keep) void'(q.pop_back());
         end
         1: q[1] = 8'($urandom);
         2: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) q.push_back(8'($urandom));
         end
         default: ;
      endcase
      send_frame(q);
   endtask

   task automatic test_random_frames();
      int goal;
      logic [15:0] start;
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         steady_flow = (phase == 2);
         start = (phase == 0) ? 16'h0000 : (phase == 1) ? 16'hFFFF : 16'($urandom);
         configure(1'(phase % 2), start, 3'(2 + phase % 3));
         goal = bytes_taken + 1;
         while (bytes_taken < goal) random_frame();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.frame_byte <= 8'd0;
      req_chan.first_of_frame <= 1'b0;
      req_chan.end_of_frame <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_ROLE;
      csr_write_data <= 16'd0;
      reset <= 1'b1;
      cfg_slave = 1'b0;
      cfg_start = 16'd0;
      cfg_reg_bytes = 3'd4;
      fr_pos = 0;
      fr_dev = 8'd0;
      clear_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_master_functions();
      test_frame_status();
      test_framing();
      test_role_switch();
      test_slave_functions();
      test_random_frames();
      settle();
      if (fail_count == 0) begin
         $display("modbus_frame_payload_parser test passed");
      end else begin
         $display("modbus_frame_payload_parser test failed");
      end
      $finish;
   end

endmodule
